@@ src/stab_pkg.sv @@
// ----------------------------------------------------------------------------
// stab_pkg
// Shared types and constants for the slot table with age bands.
// ----------------------------------------------------------------------------
package stab_pkg;

    // field widths of the command and result words
    localparam int ID_W    = 27;
    localparam int AGE_W   = 7;
    localparam int SLOT_W  = 6;
    localparam int FIELD_W = 7;

    // default number of table slots
    localparam int TABLE_DEPTH_DEF = 64;

    // age limits and band edges
    localparam logic [AGE_W-1:0] AGE_MIN    = 7'd1;
    localparam logic [AGE_W-1:0] AGE_MAX    = 7'd102;
    localparam logic [AGE_W-1:0] MIDDLE_LOW = 7'd18;
    localparam logic [AGE_W-1:0] OLD_LOW    = 7'd36;

    // percentage scale and count saturation
    localparam int PCT_SCALE = 100;
    localparam int COUNT_MAX = 127;

    // band index inside the count vector
    localparam int BAND_YOUNG  = 0;
    localparam int BAND_MIDDLE = 1;
    localparam int BAND_OLD    = 2;

    typedef enum logic [1:0] {
        ACT_CLEAR  = 2'd0,
        ACT_INSERT = 2'd1,
        ACT_DELETE = 2'd2,
        ACT_REPORT = 2'd3
    } t_action;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_FULL      = 2'd1,
        ST_NOT_FOUND = 2'd2,
        ST_BAD_AGE   = 2'd3
    } t_status;

    // command word
    typedef struct packed {
        t_action             action;
        logic [ID_W-1:0]     id_number;
        logic [AGE_W-1:0]    age;
    } t_in_word;

    // result word
    typedef struct packed {
        t_status             status;
        logic [SLOT_W-1:0]   slot;
        logic [FIELD_W-1:0]  count_young;
        logic [FIELD_W-1:0]  count_middle;
        logic [FIELD_W-1:0]  count_old;
        logic [FIELD_W-1:0]  count_largest;
        logic [FIELD_W-1:0]  pct_young;
        logic [FIELD_W-1:0]  pct_middle;
        logic [FIELD_W-1:0]  pct_old;
    } t_out_word;

    // command held for the whole scan, seen by every cell
    typedef struct packed {
        t_action             action;
        logic [ID_W-1:0]     id_number;
        logic [AGE_W-1:0]    age;
        logic                age_ok;
    } t_bcast;

    // scan token handed from cell to cell
    typedef struct packed {
        logic act;
        logic hit;
    } t_link;

endpackage

@@ src/stab_cell.sv @@
// ----------------------------------------------------------------------------
// stab_cell
// One table slot. Acts on the command when the scan token reaches it and
// passes the token, band counts and hit slot on to the next cell.
// ----------------------------------------------------------------------------
module stab_cell
    import stab_pkg::*;
#(
    parameter int CELL_INDEX = 0,
    parameter int IW         = SLOT_W,
    parameter int CW         = FIELD_W
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  t_bcast                 i_bcast,
    input  t_link                  i_link,
    input  logic [2:0][CW-1:0]     i_cnt,
    input  logic [IW-1:0]          i_slot,
    output t_link                  o_link,
    output logic [2:0][CW-1:0]     o_cnt,
    output logic [IW-1:0]          o_slot
);

    localparam logic [IW-1:0] MY_SLOT = IW'(CELL_INDEX);

    logic                r_used, n_used;
    logic [ID_W-1:0]     r_id;
    logic [AGE_W-1:0]    r_age;
    logic                n_write;
    t_link               r_link, n_link;
    logic [2:0][CW-1:0]  r_cnt, n_cnt;
    logic [IW-1:0]       r_slot, n_slot;

    // slot action while the token is here
    always_comb begin
        logic take;
        take    = i_link.act && !i_link.hit;
        n_used  = r_used;
        n_write = 1'b0;
        n_link  = i_link;
        n_cnt   = i_cnt;
        n_slot  = i_slot;
        case (i_bcast.action)
            ACT_CLEAR: begin
                if (i_link.act) begin
                    n_used = 1'b0;
                end
            end
            ACT_INSERT: begin
                if (take && !r_used) begin
                    n_link.hit = 1'b1;
                    n_slot     = MY_SLOT;
                    if (i_bcast.age_ok) begin
                        n_used  = 1'b1;
                        n_write = 1'b1;
                    end
                end
            end
            ACT_DELETE: begin
                if (take && r_used && (r_id == i_bcast.id_number)) begin
                    n_used     = 1'b0;
                    n_link.hit = 1'b1;
                    n_slot     = MY_SLOT;
                end
            end
            ACT_REPORT: begin
                if (i_link.act && r_used) begin
                    if (r_age < MIDDLE_LOW) begin
                        n_cnt[BAND_YOUNG] = i_cnt[BAND_YOUNG] + CW'(1);
                    end else if (r_age < OLD_LOW) begin
                        n_cnt[BAND_MIDDLE] = i_cnt[BAND_MIDDLE] + CW'(1);
                    end else begin
                        n_cnt[BAND_OLD] = i_cnt[BAND_OLD] + CW'(1);
                    end
                end
            end
            default: begin
                n_used = r_used;
            end
        endcase
    end

    // slot contents and hand-off registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used <= 1'b0;
            r_link <= '0;
        end else begin
            r_used <= n_used;
            r_link <= n_link;
        end
        if (n_write) begin
            r_id  <= i_bcast.id_number;
            r_age <= i_bcast.age;
        end
        r_cnt  <= n_cnt;
        r_slot <= n_slot;
    end

    assign o_link = r_link;
    assign o_cnt  = r_cnt;
    assign o_slot = r_slot;

endmodule

@@ src/stab_pct.sv @@
// ----------------------------------------------------------------------------
// stab_pct
// Percentage unit: floor(band * 100 / total), one quotient bit per cycle while i_step is high.
// ----------------------------------------------------------------------------
module stab_pct
    import stab_pkg::*;
#(
    parameter int CW = FIELD_W
) (
    input  logic                i_clk,
    input  logic                i_load,
    input  logic                i_step,
    input  logic [2:0]          i_bit,
    input  logic [CW-1:0]       i_band,
    input  logic [CW-1:0]       i_total,
    output logic [FIELD_W-1:0]  o_pct
);

    // band * 100 stays below band * 128
    localparam int DW = CW + FIELD_W;

    logic [DW-1:0]       r_rem;
    logic [CW-1:0]       r_div;
    logic [FIELD_W-1:0]  r_q;
    logic [DW-1:0]       w_shift;
    logic                w_fit;

    // trial subtract of the divisor at the current bit
    assign w_shift = DW'(r_div) << i_bit;
    assign w_fit   = (r_rem >= w_shift);

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_rem <= DW'(i_band) * DW'(PCT_SCALE);
            r_div <= i_total;
            r_q   <= '0;
        end else if (i_step && w_fit) begin
            r_rem        <= r_rem - w_shift;
            r_q[i_bit]   <= 1'b1;
        end
    end

    assign o_pct = r_q;

endmodule

@@ src/slot_table_with_age_bands.sv @@
// ----------------------------------------------------------------------------
// slot_table_with_age_bands
// Table of person slots (ID, age, used) kept in a chain of cells, with
// clear, insert, delete by ID and age band report.
// ----------------------------------------------------------------------------
//  channel   | ports                  | handshake
//  ----------+------------------------+-----------------------------------
//  command   | start, busy, i_cmd     | word taken when start && !busy
//  result    | o_done, o_result       | word valid for the one o_done cycle
//
//  A scan token walks the cell chain one slot per cycle; for clear, insert
//  and delete o_done rises once the token has left the last cell. A report
//  then runs the bit-serial percentage units before o_done rises.
//  busy is high from the cycle after accept until o_done; one word at a time.
//  Reset is synchronous and frees every slot at once; no clearing pass.
//  The result side has no back-pressure.
// ----------------------------------------------------------------------------
module slot_table_with_age_bands
    import stab_pkg::*;
#(
    parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       start,
    output logic       busy,
    input  t_in_word   i_cmd,
    output logic       o_done,
    output t_out_word  o_result
);

    localparam int IW  = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CW  = $clog2(TABLE_DEPTH + 1);
    localparam int SXW = (IW > SLOT_W) ? IW : SLOT_W;
    localparam int SW  = (CW > FIELD_W) ? CW : FIELD_W;
    localparam logic [2:0] PCT_MSB = 3'(FIELD_W - 1);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_SCAN = 4'b0010,
        S_DIV  = 4'b0100,
        S_FIN  = 4'b1000
    } t_state;

    t_state              r_state, n_state;
    t_bcast              r_bcast;
    t_link               r_head;
    logic [2:0][CW-1:0]  r_cnt;
    logic [CW-1:0]       r_total;
    logic [2:0]          r_bit;
    logic                r_done, n_done;
    t_out_word           r_result, n_result;

    t_link               w_link [0:TABLE_DEPTH];
    logic [2:0][CW-1:0]  w_cnt  [0:TABLE_DEPTH];
    logic [IW-1:0]       w_slot [0:TABLE_DEPTH];

    logic                w_accept;
    t_link               w_tail;
    logic [CW-1:0]       w_tail_total;
    logic [SXW-1:0]      w_slot_ext;
    logic                w_load;
    logic                w_step;
    logic [2:0][FIELD_W-1:0] w_pct;

    // saturate a band count to the 7-bit field
    function automatic logic [FIELD_W-1:0] sat_count(input logic [CW-1:0] cnt);
        logic [SW-1:0] ext;
        ext = SW'(cnt);
        if (ext > SW'(COUNT_MAX)) begin
            return FIELD_W'(COUNT_MAX);
        end
        return ext[FIELD_W-1:0];
    endfunction

    assign w_accept = start && (r_state == S_IDLE);
    assign busy     = (r_state != S_IDLE);

    // head of the chain
    assign w_link[0] = r_head;
    assign w_cnt[0]  = '0;
    assign w_slot[0] = '0;

    // cell chain
    for (genvar g = 0; g < TABLE_DEPTH; g++) begin : g_cell
        stab_cell #(
            .CELL_INDEX (g),
            .IW         (IW),
            .CW         (CW)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_bcast (r_bcast),
            .i_link  (w_link[g]),
            .i_cnt   (w_cnt[g]),
            .i_slot  (w_slot[g]),
            .o_link  (w_link[g+1]),
            .o_cnt   (w_cnt[g+1]),
            .o_slot  (w_slot[g+1])
        );
    end

    // tail of the chain
    assign w_tail       = w_link[TABLE_DEPTH];
    assign w_tail_total = CW'(({2'b00, w_cnt[TABLE_DEPTH][BAND_YOUNG]}
                              + {2'b00, w_cnt[TABLE_DEPTH][BAND_MIDDLE]})
                              + {2'b00, w_cnt[TABLE_DEPTH][BAND_OLD]});
    assign w_slot_ext   = SXW'(w_slot[TABLE_DEPTH]);

    // percentage units, one per band
    assign w_load = (r_state == S_SCAN) && w_tail.act && (r_bcast.action == ACT_REPORT);
    assign w_step = (r_state == S_DIV);

    for (genvar b = 0; b < 3; b++) begin : g_pct
        stab_pct #(
            .CW (CW)
        ) u_pct (
            .i_clk   (i_clk),
            .i_load  (w_load),
            .i_step  (w_step),
            .i_bit   (r_bit),
            .i_band  (w_cnt[TABLE_DEPTH][b]),
            .i_total (w_tail_total),
            .o_pct   (w_pct[b])
        );
    end

    // sequencer and result assembly
    always_comb begin
        logic [CW-1:0] largest;
        n_state  = r_state;
        n_done   = 1'b0;
        n_result = '0;
        largest  = r_cnt[BAND_YOUNG];
        if (r_cnt[BAND_MIDDLE] > largest) begin
            largest = r_cnt[BAND_MIDDLE];
        end
        if (r_cnt[BAND_OLD] > largest) begin
            largest = r_cnt[BAND_OLD];
        end
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                if (w_tail.act) begin
                    if (r_bcast.action == ACT_REPORT) begin
                        n_state = S_DIV;
                    end else begin
                        n_state = S_IDLE;
                        n_done  = 1'b1;
                        case (r_bcast.action)
                            ACT_INSERT: begin
                                if (!w_tail.hit) begin
                                    n_result.status = ST_FULL;
                                end else if (!r_bcast.age_ok) begin
                                    n_result.status = ST_BAD_AGE;
                                end else begin
                                    n_result.slot = w_slot_ext[SLOT_W-1:0];
                                end
                            end
                            ACT_DELETE: begin
                                if (w_tail.hit) begin
                                    n_result.slot = w_slot_ext[SLOT_W-1:0];
                                end else begin
                                    n_result.status = ST_NOT_FOUND;
                                end
                            end
                            default: begin
                                n_result.status = ST_OK;
                            end
                        endcase
                    end
                end
            end
            S_DIV: begin
                if (r_bit == 3'd0) begin
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                n_state                = S_IDLE;
                n_done                 = 1'b1;
                n_result.count_young   = sat_count(r_cnt[BAND_YOUNG]);
                n_result.count_middle  = sat_count(r_cnt[BAND_MIDDLE]);
                n_result.count_old     = sat_count(r_cnt[BAND_OLD]);
                n_result.count_largest = sat_count(largest);
                if (r_total != '0) begin
                    n_result.pct_young  = w_pct[BAND_YOUNG];
                    n_result.pct_middle = w_pct[BAND_MIDDLE];
                    n_result.pct_old    = w_pct[BAND_OLD];
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_head  <= '0;
            r_done  <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_head.act <= w_accept;
            r_head.hit <= 1'b0;
            r_done     <= n_done;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_bcast.action    <= i_cmd.action;
            r_bcast.id_number <= i_cmd.id_number;
            r_bcast.age       <= i_cmd.age;
            r_bcast.age_ok    <= (i_cmd.age >= AGE_MIN) && (i_cmd.age <= AGE_MAX);
        end
        if (w_load) begin
            r_cnt   <= w_cnt[TABLE_DEPTH];
            r_total <= w_tail_total;
            r_bit   <= PCT_MSB;
        end else if (w_step) begin
            r_bit <= r_bit - 3'd1;
        end
        if (n_done) begin
            r_result <= n_result;
        end
    end

    assign o_done   = r_done;
    assign o_result = r_result;

endmodule

@@ src/stab_check.sv @@
// ----------------------------------------------------------------------------
// stab_check
// Port-level checks for the slot table with age bands.
// ----------------------------------------------------------------------------
module stab_check
    import stab_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       start,
    input  logic       busy,
    input  t_in_word   i_cmd,
    input  logic       o_done,
    input  t_out_word  o_result
);

    // an accepted word keeps the block busy
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("busy not raised after accepted word");

    // a result word frees the block and lasts one cycle
    a_done_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> (!busy ##1 !o_done))
        else $error("result strobe overlaps busy or repeats");

    // failed commands carry no slot, no largest count and no percentages
    a_fail_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && (o_result.status != ST_OK)) |->
        ((o_result.slot == '0) && (o_result.count_largest == '0)
         && (o_result.pct_young == '0) && (o_result.pct_middle == '0)
         && (o_result.pct_old == '0)))
        else $error("failed command returned slot or counts");

    // floor percentages never add past 100, largest covers each band
    a_report_sane: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |->
        (((9'(o_result.pct_young) + 9'(o_result.pct_middle)
           + 9'(o_result.pct_old)) <= 9'(PCT_SCALE))
         && (o_result.count_largest >= o_result.count_young)
         && (o_result.count_largest >= o_result.count_middle)
         && (o_result.count_largest >= o_result.count_old)))
        else $error("inconsistent report word");

endmodule

bind slot_table_with_age_bands stab_check u_stab_check (.*);
